// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the memory hole block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PHMB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PHMB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/phmb_pkg.sv =====
// Package with the constants and types of the memory hole byte access block.
`timescale 1ns / 1ps

package phmb_pkg;

    // Size of the byte store and the width of an index into it.
    localparam int unsigned MEM_BYTES = 1048576;
    localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);

    // Field widths of items and registers.
    localparam int unsigned BUS_ADDR_W = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LANE_W     = 2;
    localparam int unsigned SIZE_W     = 21;
    localparam int unsigned HW_W       = 20;
    localparam int unsigned LATCH_W    = 32;

    // Address map of the emulated PC.
    localparam int unsigned           HI_BLOCK_BIT = 20;
    localparam logic [BUS_ADDR_W-1:0] HOLE_START   = 32'h000A_0000;
    localparam logic [BUS_ADDR_W-1:0] HOLE_SHIFT   = 32'h0010_0000 - 32'h000A_0000;
    localparam logic [BUS_ADDR_W-1:0] STORE_LIMIT  = BUS_ADDR_W'(MEM_BYTES);
    localparam logic [ADDR_W-1:0]     LAST_ENTRY   = ADDR_W'(MEM_BYTES - 1);

    // Lane used by an open-bus read when the bus latch is left alone.
    localparam logic [LANE_W-1:0] OPEN_BUS_LANE = 2'd3;

    // Access kinds.
    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    // Configuration port: one 32-bit register per word.
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam logic        REG_MEM_SIZE = 1'b0;

endpackage

// ===== rtl/phmb_if.sv =====
// Handshake channels for access items and result items.
`timescale 1ns / 1ps

interface phmb_req_if import phmb_pkg::*; ;
    logic                  valid;
    logic                  ready;
    cmd_t                  cmd;
    logic [BUS_ADDR_W-1:0] address;
    logic [BYTE_W-1:0]     write_data;
    logic [LANE_W-1:0]     lane;
    logic                  bus_ignore;

    modport source (output valid, cmd, address, write_data, lane, bus_ignore, input ready);
    modport sink   (input valid, cmd, address, write_data, lane, bus_ignore, output ready);
endinterface

interface phmb_rsp_if import phmb_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              invalid;
    logic [HW_W-1:0]   high_water;

    modport source (output valid, read_data, invalid, high_water, input ready);
    modport sink   (input valid, read_data, invalid, high_water, output ready);
endinterface

// ===== rtl/phmb_ram.sv =====
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module phmb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; the read data appears after the edge.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/pc_memory_hole_byte_access.sv =====
// Byte-wide PC physical memory with the 640K hole closed, a bus latch and a high-water mark.
// After reset the block first zeroes its 1,048,576-byte store, one byte per cycle, so no
// item is accepted until the sweep is done (configuration writes are taken throughout).
// Then a write or an invalid read is answered at once and a valid read passes a read state:
// the store is a single-port RAM whose read data arrives in the cycle after the address.
// A result waits in an output register; the next item is taken in the same cycle that
// the waiting result is taken. Addresses with bit 20 set are lowered by 0x60000, others
// at or above 0xA0000 are invalid, as is anything at or beyond mem_size. Invalid writes
// are dropped and invalid reads return the open-bus byte of the latch.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pc_memory_hole_byte_access import phmb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    phmb_req_if.sink           req,
    phmb_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [SIZE_W-1:0]    mem_size_reg, mem_size_next;
    logic [LATCH_W-1:0]   latch_reg, latch_next;
    logic [ADDR_W-1:0]    hw_reg, hw_next;
    logic [LANE_W-1:0]    rd_lane_reg, rd_lane_next;
    logic                 rd_ignore_reg, rd_ignore_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [BYTE_W-1:0]    rsp_data_reg, rsp_data_next;
    logic                 rsp_invalid_reg, rsp_invalid_next;
    logic [HW_W-1:0]      rsp_hw_reg, rsp_hw_next;

    logic [BUS_ADDR_W-1:0] limit;
    logic [BUS_ADDR_W-1:0] remap;
    logic                  bad;
    logic [ADDR_W-1:0]     mem_addr;
    logic                  accept;
    logic                  cfg_wr;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [BYTE_W-1:0]     ram_wdata;
    logic [BYTE_W-1:0]     ram_rdata;
    logic [LANE_W-1:0]     open_lane;

    // Returns the latch with one byte lane replaced.
    function automatic logic [LATCH_W-1:0] put_lane(
        input logic [LATCH_W-1:0] latch,
        input logic [LANE_W-1:0]  ln,
        input logic [BYTE_W-1:0]  data
    );
        logic [LATCH_W-1:0] keep;
        keep = ~(LATCH_W'(8'hFF) << {ln, 3'b000});
        return (latch & keep) | (LATCH_W'(data) << {ln, 3'b000});
    endfunction

    // Configuration port: writes complete in the access phase, reads are immediate.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[PADDR_W-1:2] == REG_MEM_SIZE) ? PDATA_W'(mem_size_reg) : '0;

    always_comb
    begin
        mem_size_next = mem_size_reg;
        if (cfg_wr && paddr[PADDR_W-1:2] == REG_MEM_SIZE)
        begin
            mem_size_next = pwdata[SIZE_W-1:0];
        end
    end

    // Address decode: close the hole and check against the installed size.
    assign limit = (BUS_ADDR_W'(mem_size_reg) > STORE_LIMIT) ? STORE_LIMIT
                                                             : BUS_ADDR_W'(mem_size_reg);
    assign remap = req.address[HI_BLOCK_BIT] ? (req.address - HOLE_SHIFT) : req.address;
    assign bad   = (!req.address[HI_BLOCK_BIT] && req.address >= HOLE_START)
                || (remap >= limit);
    assign mem_addr = remap[ADDR_W-1:0];

    // An item is taken when idle and the output slot is free or emptying.
    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign open_lane = req.bus_ignore ? OPEN_BUS_LANE : req.lane;

    // Store port: the clearing sweep, or the access of the item just taken.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = mem_addr;
        ram_wdata = req.write_data;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (accept && !bad && req.cmd == CMD_WRITE)
        begin
            ram_we = 1'b1;
        end
    end

    phmb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer, bus latch, high-water mark and the output register.
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        latch_next       = latch_reg;
        hw_next          = hw_reg;
        rd_lane_next     = rd_lane_reg;
        rd_ignore_next   = rd_ignore_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_data_next    = rsp_data_reg;
        rsp_invalid_next = rsp_invalid_reg;
        rsp_hw_next      = rsp_hw_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ENTRY)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_WRITE)
                    begin
                        // Unless bus_ignore is set, a write drives its lane even when the address is invalid.
                        if (!req.bus_ignore)
                        begin
                            latch_next = put_lane(latch_reg, req.lane, req.write_data);
                        end
                        if (!bad && mem_addr > hw_reg)
                        begin
                            hw_next = mem_addr;
                        end
                        rsp_valid_next   = 1'b1;
                        rsp_data_next    = '0;
                        rsp_invalid_next = bad;
                        rsp_hw_next      = (!bad && mem_addr > hw_reg) ? mem_addr[HW_W-1:0]
                                                                       : hw_reg[HW_W-1:0];
                    end
                    else if (bad)
                    begin
                        // Open bus: return the latch byte, leave the latch alone.
                        rsp_valid_next   = 1'b1;
                        rsp_data_next    = BYTE_W'(latch_reg >> {open_lane, 3'b000});
                        rsp_invalid_next = 1'b1;
                        rsp_hw_next      = hw_reg[HW_W-1:0];
                    end
                    else
                    begin
                        rd_lane_next   = req.lane;
                        rd_ignore_next = req.bus_ignore;
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // Store data is back; the output slot is known to be empty here.
                if (!rd_ignore_reg)
                begin
                    latch_next = put_lane(latch_reg, rd_lane_reg, ram_rdata);
                end
                rsp_valid_next   = 1'b1;
                rsp_data_next    = ram_rdata;
                rsp_invalid_next = 1'b0;
                rsp_hw_next      = hw_reg[HW_W-1:0];
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mem_size_reg  <= SIZE_W'(MEM_BYTES);
            latch_reg     <= '0;
            hw_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            mem_size_reg  <= mem_size_next;
            latch_reg     <= latch_next;
            hw_reg        <= hw_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_lane_reg     <= rd_lane_next;
        rd_ignore_reg   <= rd_ignore_next;
        rsp_data_reg    <= rsp_data_next;
        rsp_invalid_reg <= rsp_invalid_next;
        rsp_hw_reg      <= rsp_hw_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_data  = rsp_data_reg;
    assign rsp.invalid    = rsp_invalid_reg;
    assign rsp.high_water = rsp_hw_reg;

    // A pending store read always delivers its item in the next cycle.
    `PHMB_ASSERT(a_read_completes, state_reg == ST_READ |=> rsp_valid_reg, "store read did not produce an item")

    // The output slot must be free while a store read is in flight.
    `PHMB_ASSERT(a_slot_free_in_read, state_reg == ST_READ |-> !rsp_valid_reg, "output slot busy during store read")

    // The high-water mark never falls.
    `PHMB_ASSERT(a_hw_rises, 1'b1 |=> hw_reg >= $past(hw_reg), "high-water mark decreased")

    // No item is taken while the store is being cleared.
    `PHMB_ASSERT_ALWAYS(a_no_item_in_clear, state_reg == ST_CLEAR |-> !accept, "item accepted during clearing sweep")

endmodule
